[hw/rtl/nsc_pkg.sv]
`timescale 1ns / 1ps

package nsc_pkg;

  localparam int MAX_LEN = 64;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CHAR_W  = 8;
  localparam int VAL_W   = 63;

  localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

  localparam logic [1:0] ORD_LT = 2'b11;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;

  typedef logic [1:0] res_sel_t;
  localparam res_sel_t RES_BYTE = 2'd0;
  localparam res_sel_t RES_VAL  = 2'd1;
  localparam res_sel_t RES_ALP  = 2'd2;

  typedef struct packed {
    logic     load;
    logic     walk_start;
    logic     run_init;
    logic     dig_step;
    logic     alp_step;
    logic     adv_dig;
    logic     adv_alp;
    logic     res;
    res_sel_t res_sel;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic head_end;
    logic head_mismatch;
    logic head_digit;
    logic dig_done;
    logic alp_decide;
    logic alp_done;
    logic val_eq;
  } status_t;

endpackage

[hw/rtl/nsc_ram.sv]
`timescale 1ns / 1ps

module nsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/nsc_datapath.sv]
`timescale 1ns / 1ps

module nsc_datapath
  import nsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [CHAR_W-1:0] char_a,
  input  logic [CHAR_W-1:0] char_b,
  output status_t           st,
  output logic [1:0]        order,
  output logic              too_long
);

  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_LEN);

  logic [LEN_W-1:0]  len_a_r, len_b_r, load_idx_r, pos_r, cur_r, ea_r;
  logic              ovf_r;
  logic              acta_r, actb_r;
  logic [VAL_W-1:0]  va_r, vb_r;
  logic [1:0]        order_r, out_order_r;
  logic              out_tl_r;

  logic              hit_a, hit_b, wr_a, wr_b, at_cap;
  logic [CHAR_W-1:0] q_a, q_b, ca, cb;
  logic              da, db, ina, inb;
  logic [LEN_W-1:0]  len_min;
  logic [VAL_W-1:0]  va_nxt, vb_nxt;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [1:0] sign_of(input logic [CHAR_W-1:0] x,
                                         input logic [CHAR_W-1:0] y);
    logic [1:0] s;
    if (x < y) begin
      s = ORD_LT;
    end else if (x > y) begin
      s = ORD_GT;
    end else begin
      s = ORD_EQ;
    end
    return s;
  endfunction

  // saturating v*10 + digit
  function automatic logic [VAL_W-1:0] acc_digit(input logic [VAL_W-1:0]  v,
                                                 input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] dd;
    logic [VAL_W+3:0]  t;
    dd = c - 8'h30;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{VAL_W{1'b0}}, dd[3:0]};
    return (t[VAL_W+3:VAL_W] != 4'd0) ? VALUE_MAX : t[VAL_W-1:0];
  endfunction

  assign at_cap = (load_idx_r == LEN_CAP);
  assign hit_a  = (char_a != '0) && (len_a_r == load_idx_r);
  assign hit_b  = (char_b != '0) && (len_b_r == load_idx_r);
  assign wr_a   = cmd.load && hit_a && !at_cap;
  assign wr_b   = cmd.load && hit_b && !at_cap;

  nsc_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_ram_a (
    .clk   (clk),
    .we    (wr_a),
    .waddr (load_idx_r[ADDR_W-1:0]),
    .wdata (char_a),
    .raddr (cur_r[ADDR_W-1:0]),
    .rdata (q_a)
  );

  nsc_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_ram_b (
    .clk   (clk),
    .we    (wr_b),
    .waddr (load_idx_r[ADDR_W-1:0]),
    .wdata (char_b),
    .raddr (cur_r[ADDR_W-1:0]),
    .rdata (q_b)
  );

  // past the end of a string reads as zero
  assign ca      = (cur_r < len_a_r) ? q_a : '0;
  assign cb      = (cur_r < len_b_r) ? q_b : '0;
  assign da      = is_digit(ca);
  assign db      = is_digit(cb);
  assign ina     = (cur_r < len_a_r) && !da;
  assign inb     = (cur_r < len_b_r) && !db;
  assign len_min = (len_a_r < len_b_r) ? len_a_r : len_b_r;
  assign va_nxt  = acc_digit(va_r, ca);
  assign vb_nxt  = acc_digit(vb_r, cb);

  always_comb begin
    st.head_end      = (pos_r >= len_min);
    st.head_mismatch = (da != db);
    st.head_digit    = da;
    st.dig_done      = (!acta_r || !da) && (!actb_r || !db);
    st.alp_decide    = (ina && inb && (ca != cb)) || (ina != inb);
    st.alp_done      = !ina && !inb;
    st.val_eq        = (va_r == vb_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r    <= '0;
      len_b_r    <= '0;
      load_idx_r <= '0;
      ovf_r      <= 1'b0;
      pos_r      <= '0;
      cur_r      <= '0;
      acta_r     <= 1'b0;
      actb_r     <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (wr_a) begin
          len_a_r <= load_idx_r + 1'b1;
        end
        if (wr_b) begin
          len_b_r <= load_idx_r + 1'b1;
        end
        if (at_cap && (hit_a || hit_b)) begin
          ovf_r <= 1'b1;
        end
        if (!at_cap) begin
          load_idx_r <= load_idx_r + 1'b1;
        end
      end
      if (cmd.walk_start) begin
        pos_r <= '0;
        cur_r <= '0;
      end
      if (cmd.run_init) begin
        acta_r <= 1'b1;
        actb_r <= 1'b1;
      end
      if (cmd.dig_step) begin
        if (acta_r && !da) begin
          acta_r <= 1'b0;
        end
        if (actb_r && !db) begin
          actb_r <= 1'b0;
        end
        if (!st.dig_done) begin
          cur_r <= cur_r + 1'b1;
        end
      end
      if (cmd.alp_step) begin
        cur_r <= cur_r + 1'b1;
      end
      if (cmd.adv_dig) begin
        pos_r <= ea_r;
        cur_r <= ea_r;
      end
      if (cmd.adv_alp) begin
        pos_r <= cur_r;
      end
      if (cmd.emit) begin
        len_a_r    <= '0;
        len_b_r    <= '0;
        load_idx_r <= '0;
        ovf_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      va_r <= '0;
      vb_r <= '0;
    end
    if (cmd.dig_step) begin
      if (acta_r && da) begin
        va_r <= va_nxt;
      end
      if (actb_r && db) begin
        vb_r <= vb_nxt;
      end
      if (acta_r && !da) begin
        ea_r <= cur_r;
      end
    end
    if (cmd.res) begin
      case (cmd.res_sel)
        RES_VAL: order_r <= (va_r < vb_r) ? ORD_LT : ORD_GT;
        RES_ALP: begin
          if (ina && inb) begin
            order_r <= sign_of(ca, cb);
          end else begin
            order_r <= ina ? ORD_GT : ORD_LT;
          end
        end
        default: order_r <= sign_of(ca, cb);
      endcase
    end
    if (cmd.emit) begin
      out_order_r <= order_r;
      out_tl_r    <= ovf_r;
    end
  end

  assign order    = out_order_r;
  assign too_long = out_tl_r;

endmodule

[hw/rtl/nsc_ctrl.sv]
`timescale 1ns / 1ps

module nsc_ctrl
  import nsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_tlast,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t st,
  output cmd_t    cmd
);

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_HFETCH = 4'd1;
  localparam logic [3:0] S_HEAD   = 4'd2;
  localparam logic [3:0] S_DFETCH = 4'd3;
  localparam logic [3:0] S_DIG    = 4'd4;
  localparam logic [3:0] S_DCMP   = 4'd5;
  localparam logic [3:0] S_AFETCH = 4'd6;
  localparam logic [3:0] S_ALP    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.res_sel   = RES_BYTE;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) begin
            cmd.walk_start = 1'b1;
            state_nxt      = S_HFETCH;
          end
        end
      end
      S_HFETCH: state_nxt = S_HEAD;
      S_HEAD: begin
        if (st.head_end || st.head_mismatch) begin
          cmd.res     = 1'b1;
          cmd.res_sel = RES_BYTE;
          state_nxt   = S_EMIT;
        end else begin
          cmd.run_init = 1'b1;
          state_nxt    = st.head_digit ? S_DFETCH : S_AFETCH;
        end
      end
      S_DFETCH: state_nxt = S_DIG;
      S_DIG: begin
        cmd.dig_step = 1'b1;
        state_nxt    = st.dig_done ? S_DCMP : S_DFETCH;
      end
      S_DCMP: begin
        if (st.val_eq) begin
          cmd.adv_dig = 1'b1;
          state_nxt   = S_HFETCH;
        end else begin
          cmd.res     = 1'b1;
          cmd.res_sel = RES_VAL;
          state_nxt   = S_EMIT;
        end
      end
      S_AFETCH: state_nxt = S_ALP;
      S_ALP: begin
        if (st.alp_decide) begin
          cmd.res     = 1'b1;
          cmd.res_sel = RES_ALP;
          state_nxt   = S_EMIT;
        end else if (st.alp_done) begin
          cmd.adv_alp = 1'b1;
          state_nxt   = S_HFETCH;
        end else begin
          cmd.alp_step = 1'b1;
          state_nxt    = S_AFETCH;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/natural_string_compare.sv]
// loading: one byte pair per cycle; ready stays low from the last pair until emit
// comparison walk starts the cycle after the last pair and reads both buffers through
// their registered ram port: a fetch and a decide state per byte position visited,
// a head fetch and head check per run start, a value compare per digit run, then emit
// the result sits in an output register, so loading of the next strings goes on meanwhile
// reset (rst_n low, synchronous) clears lengths, load counter, overflow flag and handshake
`timescale 1ns / 1ps

module natural_string_compare
  import nsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // char_a, char_b
  input  logic        in_tlast,   // last_pair
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // order, zero pad
  output logic        out_tuser   // too_long
);

  cmd_t       cmd;
  status_t    st;
  logic [1:0] order;
  logic       too_long;
  logic       ready;

  nsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  nsc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .char_a   (in_tdata[7:0]),
    .char_b   (in_tdata[15:8]),
    .st       (st),
    .order    (order),
    .too_long (too_long)
  );

  assign in_tready = ready;
  assign out_tdata = {6'b000000, order};
  assign out_tuser = too_long;

endmodule
